// File: sv/sgcw_pkg.sv
package sgcw_pkg;

    localparam int COORD_W   = 16;
    localparam int TAG_W     = 16;
    localparam int CELL_W    = 5;
    localparam int MAX_CELLS = 63;
    localparam int CNT_W     = 6;
    // signed widths of the walk datapath
    localparam int DELTA_W   = COORD_W + 1;
    localparam int OFF_W     = COORD_W + 2;
    localparam int IDX_W     = COORD_W + 2;
    localparam int TRK_W     = COORD_W + 4;
    localparam int STEP_W    = COORD_W + DELTA_W + 1;
    localparam int PROD_W    = OFF_W + DELTA_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd2;

    localparam logic [COORD_W-1:0] CELL_SIZE_RESET = 16'd16;
    localparam logic [COORD_W-1:0] CELL_SIZE_MIN   = 16'd2;

    localparam int QDEPTH = 2;

    typedef logic signed [TRK_W-1:0]  trk_t;
    typedef logic signed [IDX_W-1:0]  idx_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [STEP_W-1:0] step_t;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [COORD_W-1:0] cell_size;
    } cfg_t;

    // one prepared segment, handed from the setup side to the walker
    typedef struct packed {
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] cs;
        trk_t               tx;
        trk_t               ty;
        idx_t               cx;
        idx_t               cy;
        prod_t              lx;
        prod_t              ry;
        step_t              csdx;
        step_t              csdy;
        logic               up_x;
        logic               up_y;
        logic               nz_x;
        logic               nz_y;
    } desc_t;

endpackage

// File: sv/segment_grid_cell_walk.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    x_start y_start x_end y_end segment_id
// out      output     out_valid / out_ready  cell_x cell_y seg_tag last
// cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data (0 origin_x, 1 origin_y,
//                                            2 cell_size)
//
// Setup finds the start cell with a shift-subtract divider, then the multiply states F_MUL1
// and F_MUL2 fill in the cross products before the queue push.
// The walker loads a segment, then emits one cell per cycle while out_ready allows, 1 to 63
// cells per segment; a 2-entry queue lets setup prepare the next segment during a walk.
// Reset is asynchronous, active low; registers return to origin 0,0 and cell size 16.
// out_ready low holds the walker; in_ready drops while setup is busy or waits on a full queue.
module segment_grid_cell_walk #(
    parameter int GRID_DIM = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sgcw_pkg::COORD_W-1:0]   x_start,
    input  logic [sgcw_pkg::COORD_W-1:0]   y_start,
    input  logic [sgcw_pkg::COORD_W-1:0]   x_end,
    input  logic [sgcw_pkg::COORD_W-1:0]   y_end,
    input  logic [sgcw_pkg::TAG_W-1:0]     segment_id,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sgcw_pkg::CELL_W-1:0]    cell_x,
    output logic [sgcw_pkg::CELL_W-1:0]    cell_y,
    output logic [sgcw_pkg::TAG_W-1:0]     seg_tag,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sgcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgcw_pkg::COORD_W-1:0]   cfg_data
);

    sgcw_pkg::cfg_t  cfg_reg;
    sgcw_pkg::desc_t push_desc;
    sgcw_pkg::desc_t head;
    logic            push, pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x  <= '0;
            cfg_reg.origin_y  <= '0;
            cfg_reg.cell_size <= sgcw_pkg::CELL_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sgcw_pkg::REG_ORIGIN_X:  cfg_reg.origin_x  <= cfg_data;
                sgcw_pkg::REG_ORIGIN_Y:  cfg_reg.origin_y  <= cfg_data;
                sgcw_pkg::REG_CELL_SIZE: cfg_reg.cell_size <= cfg_data;
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    sgcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .segment_id (segment_id),
        .push       (push),
        .push_desc  (push_desc),
        .q_full     (q_full)
    );

    sgcw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    sgcw_back #(
        .GRID_DIM (GRID_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .seg_tag   (seg_tag),
        .last      (last)
    );

endmodule

// File: sv/sgcw_div.sv
module sgcw_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sgcw_pkg::COORD_W-1:0] dividend,
    input  logic [sgcw_pkg::COORD_W-1:0] divisor,
    output logic                         done,
    output logic [sgcw_pkg::COORD_W-1:0] quotient,
    output logic [sgcw_pkg::COORD_W-1:0] remainder
);

    localparam int W     = sgcw_pkg::COORD_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [W-1:0]     num_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     den_reg;

    logic [W:0]   shifted;
    logic         fits;
    logic [W-1:0] rem_next;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted  = {rem_reg, num_reg[W-1]};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? W'(shifted - {1'b0, den_reg}) : shifted[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(W);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            num_reg  <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[W-2:0], fits};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/sgcw_front.sv
module sgcw_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sgcw_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sgcw_pkg::COORD_W-1:0] x_start,
    input  logic [sgcw_pkg::COORD_W-1:0] y_start,
    input  logic [sgcw_pkg::COORD_W-1:0] x_end,
    input  logic [sgcw_pkg::COORD_W-1:0] y_end,
    input  logic [sgcw_pkg::TAG_W-1:0]   segment_id,
    output logic                         push,
    output sgcw_pkg::desc_t              push_desc,
    input  logic                         q_full
);

    localparam int W     = sgcw_pkg::COORD_W;
    localparam int DW    = sgcw_pkg::DELTA_W;
    localparam int OW    = sgcw_pkg::OFF_W;
    localparam int IW    = sgcw_pkg::IDX_W;
    localparam int TW    = sgcw_pkg::TRK_W;
    localparam int PW    = sgcw_pkg::PROD_W;
    localparam int SW    = sgcw_pkg::STEP_W;

    typedef enum logic [2:0] {
        F_IDLE,
        F_START,
        F_DIV,
        F_FIX,
        F_MUL1,
        F_MUL2,
        F_PUSH
    } fstate_t;

    fstate_t state_reg;

    logic [W-1:0]          x0_reg, y0_reg, x1_reg, y1_reg, ox_reg, oy_reg, cs_reg;
    logic [sgcw_pkg::TAG_W-1:0] tag_reg;
    logic signed [DW-1:0]  dx_reg, dy_reg;
    logic signed [OW-1:0]  offx_reg, offy_reg;
    sgcw_pkg::desc_t       desc_reg;

    logic         neg_x, neg_y;
    logic [W-1:0] mag_x, mag_y;
    logic         div_start;
    logic         done_x, done_y;
    logic [W-1:0] qx, qy, rx, ry;

    logic                 up_x, up_y;
    logic [IW-1:0]        qx_up, qy_up;
    logic [W-1:0]         rfl_x, rfl_y;
    logic [OW-1:0]        off_x, off_y;
    sgcw_pkg::idx_t       cx_fix, cy_fix;
    sgcw_pkg::trk_t       tx_fix, ty_fix;

    assign neg_x = x0_reg < ox_reg;
    assign neg_y = y0_reg < oy_reg;
    assign mag_x = neg_x ? (ox_reg - x0_reg) : (x0_reg - ox_reg);
    assign mag_y = neg_y ? (oy_reg - y0_reg) : (y0_reg - oy_reg);
    assign div_start = (state_reg == F_START);

    sgcw_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_x),
        .divisor   (cs_reg),
        .done      (done_x),
        .quotient  (qx),
        .remainder (rx)
    );

    sgcw_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_y),
        .divisor   (cs_reg),
        .done      (done_y),
        .quotient  (qy),
        .remainder (ry)
    );

    // floor division fix-up and the tracking point one unit inside the cell
    always_comb
    begin
        up_x   = x1_reg > x0_reg;
        up_y   = y1_reg > y0_reg;
        qx_up  = IW'(qx) + IW'(rx != '0);
        qy_up  = IW'(qy) + IW'(ry != '0);
        cx_fix = neg_x ? -qx_up : IW'(qx);
        cy_fix = neg_y ? -qy_up : IW'(qy);
        rfl_x  = neg_x ? ((rx != '0) ? (cs_reg - rx) : '0) : rx;
        rfl_y  = neg_y ? ((ry != '0) ? (cs_reg - ry) : '0) : ry;
        off_x  = up_x ? (OW'(cs_reg) - OW'(1) - OW'(rfl_x)) : (OW'(1) - OW'(rfl_x));
        off_y  = up_y ? (OW'(cs_reg) - OW'(1) - OW'(rfl_y)) : (OW'(1) - OW'(rfl_y));
        tx_fix = $signed(TW'(x0_reg)) + TW'($signed(off_x));
        ty_fix = $signed(TW'(y0_reg)) + TW'($signed(off_y));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            x0_reg    <= '0;
            y0_reg    <= '0;
            x1_reg    <= '0;
            y1_reg    <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            cs_reg    <= sgcw_pkg::CELL_SIZE_MIN;
            tag_reg   <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            offx_reg  <= '0;
            offy_reg  <= '0;
            desc_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        x0_reg    <= x_start;
                        y0_reg    <= y_start;
                        x1_reg    <= x_end;
                        y1_reg    <= y_end;
                        tag_reg   <= segment_id;
                        ox_reg    <= cfg.origin_x;
                        oy_reg    <= cfg.origin_y;
                        cs_reg    <= (cfg.cell_size < sgcw_pkg::CELL_SIZE_MIN) ?
                                     sgcw_pkg::CELL_SIZE_MIN : cfg.cell_size;
                        dx_reg    <= $signed({1'b0, x_end}) - $signed({1'b0, x_start});
                        dy_reg    <= $signed({1'b0, y_end}) - $signed({1'b0, y_start});
                        state_reg <= F_START;
                    end
                end
                F_START:
                begin
                    state_reg <= F_DIV;
                end
                F_DIV:
                begin
                    if (done_x && done_y)
                        state_reg <= F_FIX;
                end
                F_FIX:
                begin
                    offx_reg       <= $signed(off_x);
                    offy_reg       <= $signed(off_y);
                    desc_reg.x_end <= x1_reg;
                    desc_reg.y_end <= y1_reg;
                    desc_reg.tag   <= tag_reg;
                    desc_reg.cs    <= cs_reg;
                    desc_reg.tx    <= tx_fix;
                    desc_reg.ty    <= ty_fix;
                    desc_reg.cx    <= cx_fix;
                    desc_reg.cy    <= cy_fix;
                    desc_reg.up_x  <= up_x;
                    desc_reg.up_y  <= up_y;
                    desc_reg.nz_x  <= dx_reg != '0;
                    desc_reg.nz_y  <= dy_reg != '0;
                    state_reg      <= F_MUL1;
                end
                F_MUL1:
                begin
                    // cross products of the boundary parameters
                    desc_reg.lx <= PW'(offx_reg) * PW'(dy_reg);
                    desc_reg.ry <= PW'(offy_reg) * PW'(dx_reg);
                    state_reg   <= F_MUL2;
                end
                F_MUL2:
                begin
                    // per-step increments of the cross products
                    desc_reg.csdy <= SW'($signed({1'b0, cs_reg})) * SW'(dy_reg);
                    desc_reg.csdx <= SW'($signed({1'b0, cs_reg})) * SW'(dx_reg);
                    state_reg     <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == F_IDLE);
    assign push      = (state_reg == F_PUSH) && !q_full;
    assign push_desc = desc_reg;

endmodule

// File: sv/sgcw_fifo.sv
module sgcw_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sgcw_pkg::desc_t push_desc,
    input  logic            pop,
    output sgcw_pkg::desc_t head,
    output logic            full,
    output logic            empty
);

    localparam int DEPTH = sgcw_pkg::QDEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sgcw_pkg::desc_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: sv/sgcw_back.sv
module sgcw_back #(
    parameter int GRID_DIM = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sgcw_pkg::desc_t             head,
    input  logic                        q_empty,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sgcw_pkg::CELL_W-1:0] cell_x,
    output logic [sgcw_pkg::CELL_W-1:0] cell_y,
    output logic [sgcw_pkg::TAG_W-1:0]  seg_tag,
    output logic                        last
);

    localparam int CW = sgcw_pkg::CELL_W;
    localparam int IW = sgcw_pkg::IDX_W;
    localparam int TW = sgcw_pkg::TRK_W;
    localparam int PW = sgcw_pkg::PROD_W;
    localparam int NW = sgcw_pkg::CNT_W;
    localparam sgcw_pkg::idx_t TOP_CELL = IW'(GRID_DIM - 1);

    sgcw_pkg::desc_t     cur_reg;
    sgcw_pkg::desc_t     cur_next;
    logic                busy_reg;
    logic [NW-1:0]       cnt_reg;
    logic                out_valid_reg;
    logic [CW-1:0]       cell_x_reg, cell_y_reg;
    logic [sgcw_pkg::TAG_W-1:0] seg_tag_reg;
    logic                last_reg;

    logic                 load_ok, emit;
    logic                 below_x, below_y, walk_done, take_x, is_last;
    logic [CW-1:0]        sat_x, sat_y;
    logic signed [1:0]    dir_x, dir_y;
    sgcw_pkg::trk_t       cs_trk, end_x, end_y;

    assign load_ok = !out_valid_reg || out_ready;
    assign emit    = busy_reg && load_ok;
    assign pop     = !busy_reg && !q_empty;

    always_comb
    begin
        cs_trk  = $signed(TW'(cur_reg.cs));
        end_x   = $signed(TW'(cur_reg.x_end));
        end_y   = $signed(TW'(cur_reg.y_end));
        dir_x   = cur_reg.up_x ? 2'sb01 : 2'sb11;
        dir_y   = cur_reg.up_y ? 2'sb01 : 2'sb11;

        below_x = cur_reg.nz_x && (cur_reg.up_x ? (cur_reg.tx < end_x) : (cur_reg.tx > end_x));
        below_y = cur_reg.nz_y && (cur_reg.up_y ? (cur_reg.ty < end_y) : (cur_reg.ty > end_y));
        walk_done = !below_x && !below_y;
        is_last   = walk_done || (cnt_reg == NW'(sgcw_pkg::MAX_CELLS - 1));

        // ties go to Y; a flat axis never steps
        priority if (!cur_reg.nz_x)
            take_x = 1'b0;
        else if (!cur_reg.nz_y)
            take_x = 1'b1;
        else if (cur_reg.up_x == cur_reg.up_y)
            take_x = cur_reg.lx < cur_reg.ry;
        else
            take_x = cur_reg.lx > cur_reg.ry;

        priority if (cur_reg.cx < 0)
            sat_x = '0;
        else if (cur_reg.cx > TOP_CELL)
            sat_x = CW'(GRID_DIM - 1);
        else
            sat_x = cur_reg.cx[CW-1:0];

        priority if (cur_reg.cy < 0)
            sat_y = '0;
        else if (cur_reg.cy > TOP_CELL)
            sat_y = CW'(GRID_DIM - 1);
        else
            sat_y = cur_reg.cy[CW-1:0];

        cur_next = cur_reg;
        if (take_x)
        begin
            cur_next.tx = cur_reg.up_x ? (cur_reg.tx + cs_trk) : (cur_reg.tx - cs_trk);
            cur_next.cx = cur_reg.cx + IW'(dir_x);
            cur_next.lx = cur_reg.up_x ? (cur_reg.lx + PW'(cur_reg.csdy))
                                       : (cur_reg.lx - PW'(cur_reg.csdy));
        end
        else
        begin
            cur_next.ty = cur_reg.up_y ? (cur_reg.ty + cs_trk) : (cur_reg.ty - cs_trk);
            cur_next.cy = cur_reg.cy + IW'(dir_y);
            cur_next.ry = cur_reg.up_y ? (cur_reg.ry + PW'(cur_reg.csdx))
                                       : (cur_reg.ry - PW'(cur_reg.csdx));
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        else if (emit && !is_last)
            cur_reg <= cur_next;

        if (emit)
        begin
            cell_x_reg  <= sat_x;
            cell_y_reg  <= sat_y;
            seg_tag_reg <= cur_reg.tag;
            last_reg    <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (pop)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (emit)
            begin
                if (is_last)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_x    = cell_x_reg;
    assign cell_y    = cell_y_reg;
    assign seg_tag   = seg_tag_reg;
    assign last      = last_reg;

endmodule

// File: tb/segment_grid_cell_walk_tb.sv
module segment_grid_cell_walk_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgcw_pkg::*;

    localparam int GRID = 32;
    localparam int QUIET_LIMIT = 5000;
    localparam int SEGS_PER_PHASE = 38;
    localparam int NUM_PHASES = 8;
    // index 3 decodes to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [TAG_W-1:0]   id;
    } seg_t;

    typedef struct packed {
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [TAG_W-1:0]  tag;
        logic              fin;
    } cell_t;

    class crossing_board #(int DIM = 32);
        cell_t              cells_due[$];
        logic [COORD_W-1:0] org_x;
        logic [COORD_W-1:0] org_y;
        logic [COORD_W-1:0] side;
        int                 mismatches;

        function new();
            org_x = '0;
            org_y = '0;
            side = CELL_SIZE_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
            case (idx)
                REG_ORIGIN_X:  org_x = val;
                REG_ORIGIN_Y:  org_y = val;
                REG_CELL_SIZE: side = val;
                default: ;
            endcase
        endfunction

        function longint eff_side();
            return (side < CELL_SIZE_MIN) ? longint'(CELL_SIZE_MIN) : longint'(side);
        endfunction

        function longint floor_div(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q -= 1;
            return q;
        endfunction

        function logic [CELL_W-1:0] clamp(longint c);
            if (c < 0)
                return '0;
            if (c > DIM - 1)
                return CELL_W'(DIM - 1);
            return CELL_W'(c);
        endfunction

        function cell_t cell_at(longint cx, longint cy, logic [TAG_W-1:0] tag);
            cell_t c;
            c.cx = clamp(cx);
            c.cy = clamp(cy);
            c.tag = tag;
            c.fin = 1'b0;
            return c;
        endfunction

        // crossing parameter (track - start) / ext still below one
        function bit short_of_end(longint track, longint stop, longint ext);
            return (ext > 0) ? (track < stop) : (track > stop);
        endfunction

        // a/b < c/d, b and d non-zero
        function bit ratio_less(longint a, longint b, longint c, longint d);
            longint l, r;
            l = a * d;
            r = c * b;
            return ((b > 0) == (d > 0)) ? (l < r) : (l > r);
        endfunction

        function void note_segment(seg_t s);
            longint cs, ox, oy, x0, y0, x1, y1, dx, dy, sx, sy, cx, cy, tx, ty;
            bit     x_open, y_open, go_x;
            cell_t  walk[$];
            cs = eff_side();
            ox = org_x;
            oy = org_y;
            x0 = s.x0;
            y0 = s.y0;
            x1 = s.x1;
            y1 = s.y1;
            dx = x1 - x0;
            dy = y1 - y0;
            sx = (x1 > x0) ? 1 : -1;
            sy = (y1 > y0) ? 1 : -1;
            cx = floor_div(x0 - ox, cs);
            cy = floor_div(y0 - oy, cs);
            // track one unit inside the cell on the side we head toward
            tx = ox + cx * cs + 1;
            ty = oy + cy * cs + 1;
            if (sx > 0)
                tx += cs - 2;
            if (sy > 0)
                ty += cs - 2;
            walk = {walk, cell_at(cx, cy, s.id)};
            while (walk.size() < MAX_CELLS)
            begin
                x_open = (dx != 0) && short_of_end(tx, x1, dx);
                y_open = (dy != 0) && short_of_end(ty, y1, dy);
                if (!x_open && !y_open)
                    break;
                if (dx == 0)
                    go_x = 1'b0;
                else if (dy == 0)
                    go_x = 1'b1;
                else
                    go_x = ratio_less(tx - x0, dx, ty - y0, dy);   // tie goes to Y
                if (go_x)
                begin
                    tx += sx * cs;
                    cx += sx;
                end
                else
                begin
                    ty += sy * cs;
                    cy += sy;
                end
                walk = {walk, cell_at(cx, cy, s.id)};
            end
            walk[walk.size() - 1].fin = 1'b1;
            foreach (walk[i])
                cells_due = {cells_due, walk[i]};
        endfunction

        task report(string what);
            mismatches++;
            $display("%t mismatch: %s", $realtime, what);
        endtask

        task check_cell(logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
                        logic [TAG_W-1:0] tag, logic fin);
            cell_t want;
            if (cells_due.size() == 0)
            begin
                report($sformatf("cell (%0d,%0d) tag %h last %b with none expected",
                                 cx, cy, tag, fin));
                return;
            end
            want = cells_due.pop_front();
            if (cx !== want.cx)
                report($sformatf("tag %h cell_x %0d, want %0d", want.tag, cx, want.cx));
            if (cy !== want.cy)
                report($sformatf("tag %h cell_y %0d, want %0d", want.tag, cy, want.cy));
            if (tag !== want.tag)
                report($sformatf("seg_tag %h, want %h", tag, want.tag));
            if (fin !== want.fin)
                report($sformatf("tag %h last %b, want %b", want.tag, fin, want.fin));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [COORD_W-1:0]   x_start = '0;
    logic [COORD_W-1:0]   y_start = '0;
    logic [COORD_W-1:0]   x_end = '0;
    logic [COORD_W-1:0]   y_end = '0;
    logic [TAG_W-1:0]     segment_id = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CELL_W-1:0]    cell_x;
    logic [CELL_W-1:0]    cell_y;
    logic [TAG_W-1:0]     seg_tag;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ORIGIN_X;
    logic [COORD_W-1:0]   cfg_data = '0;

    crossing_board #(GRID) board;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet = 0;

    segment_grid_cell_walk #(.GRID_DIM(GRID)) uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_cell(cell_x, cell_y, seg_tag, last);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic seg_t seg(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                 logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
                                 logic [TAG_W-1:0] id);
        seg_t s;
        s.x0 = x0;
        s.y0 = y0;
        s.x1 = x1;
        s.y1 = y1;
        s.id = id;
        return s;
    endfunction

    // point inside the grid, sometimes snapped onto a lower cell edge
    function automatic logic [COORD_W-1:0] grid_point(logic [COORD_W-1:0] org);
        longint cs, hi, v;
        cs = board.eff_side();
        hi = longint'(org) + GRID * cs - 1;
        if (hi > 65535)
            hi = 65535;
        v = $urandom_range(int'(hi), int'(org));
        if ($urandom_range(3) == 0)
            v = org + ((v - org) / cs) * cs;
        return COORD_W'(v);
    endfunction

    function automatic logic [COORD_W-1:0] shifted(logic [COORD_W-1:0] p, longint d);
        longint up, dn;
        up = longint'(p) + d;
        dn = longint'(p) - d;
        if (up > 65535 || (dn >= 0 && $urandom_range(1) == 1))
            return COORD_W'(dn);
        return COORD_W'(up);
    endfunction

    function automatic seg_t make_segment();
        seg_t   s;
        int     kind;
        longint d;
        kind = $urandom_range(99);
        s.id = TAG_W'($urandom);
        s.x0 = grid_point(board.org_x);
        s.y0 = grid_point(board.org_y);
        s.x1 = grid_point(board.org_x);
        s.y1 = grid_point(board.org_y);
        if (kind >= 60 && kind < 75)
        begin
            // exact diagonal, hits corners when the start is snapped
            d = $urandom_range(600);
            s.x1 = shifted(s.x0, d);
            s.y1 = shifted(s.y0, d);
        end
        else if (kind >= 75 && kind < 87)
        begin
            case ($urandom_range(2))
                0: s.x1 = s.x0;
                1: s.y1 = s.y0;
                default:
                begin
                    s.x1 = s.x0;
                    s.y1 = s.y0;
                end
            endcase
        end
        else if (kind >= 87)
        begin
            s.x0 = COORD_W'($urandom);
            s.y0 = COORD_W'($urandom);
            s.x1 = COORD_W'($urandom);
            s.y1 = COORD_W'($urandom);
        end
        return s;
    endfunction

    task automatic send_segment(input seg_t s);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        x_start <= s.x0;
        y_start <= s.y0;
        x_end <= s.x1;
        y_end <= s.y1;
        segment_id <= s.id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_segment(s);
    endtask

    task automatic release_in();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.cells_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_grid(input int p);
        logic [COORD_W-1:0] ox, oy, cs;
        case (p)
            0:
            begin
                ox = 16'd0;
                oy = 16'd0;
                cs = 16'd2;
            end
            1:
            begin
                ox = 16'd1000;
                oy = 16'd2000;
                cs = 16'd0;
            end
            2:
            begin
                ox = 16'hFFFF;
                oy = 16'hFFFF;
                cs = 16'hFFFF;
            end
            3:
            begin
                ox = 16'd0;
                oy = 16'd0;
                cs = 16'hFFFF;
            end
            4:
            begin
                ox = 16'd100;
                oy = 16'd37;
                cs = 16'd1;
            end
            5:
            begin
                ox = COORD_W'($urandom);
                oy = COORD_W'($urandom);
                cs = COORD_W'($urandom_range(200, 3));
            end
            6:
            begin
                ox = COORD_W'($urandom_range(30000));
                oy = COORD_W'($urandom_range(30000));
                cs = COORD_W'($urandom_range(2500, 201));
            end
            default:
            begin
                ox = 16'd0;
                oy = 16'd0;
                cs = 16'd2048;
            end
        endcase
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_CELL_SIZE, cs);
        if (p == 1)
            write_reg(REG_SPARE, 16'h0005);   // must not disturb any register
    endtask

    initial
    begin
        board = new();
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset grid: origin 0,0, 16-unit cells
        send_segment(seg(16'd0, 16'd0, 16'd0, 16'd0, 16'h0000));
        send_segment(seg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_segment(seg(16'd5, 16'd100, 16'd300, 16'd100, 16'd1));
        send_segment(seg(16'd300, 16'd100, 16'd5, 16'd100, 16'd2));
        send_segment(seg(16'd100, 16'd5, 16'd100, 16'd400, 16'd3));
        send_segment(seg(16'd100, 16'd400, 16'd100, 16'd5, 16'd4));
        // through cell corners: ties step Y
        send_segment(seg(16'd0, 16'd0, 16'd64, 16'd64, 16'd5));
        send_segment(seg(16'd64, 16'd64, 16'd0, 16'd0, 16'd6));
        send_segment(seg(16'd15, 16'd15, 16'd48, 16'd48, 16'd7));
        // start on a lower edge heading down
        send_segment(seg(16'd32, 16'd40, 16'd10, 16'd40, 16'd8));
        send_segment(seg(16'd40, 16'd32, 16'd40, 16'd3, 16'd9));
        send_segment(seg(16'd32, 16'd32, 16'd0, 16'd0, 16'd10));
        // long walks, cut at the cell limit
        send_segment(seg(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd11));
        send_segment(seg(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd12));
        send_segment(seg(16'd3, 16'd2, 16'd20, 16'd500, 16'd13));
        send_segment(seg(16'd500, 16'd20, 16'd2, 16'd3, 16'd14));
        send_segment(seg(16'd0, 16'd0, 16'd511, 16'd511, 16'd15));
        send_segment(seg(16'd511, 16'd0, 16'd0, 16'd511, 16'd16));
        send_segment(seg(16'd16, 16'd0, 16'd16, 16'd0, 16'd17));
        // starts off the grid, indices clamp
        send_segment(seg(16'd600, 16'd700, 16'd20, 16'd10, 16'd18));
        send_segment(seg(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hA5A5));
        send_segment(seg(16'd255, 16'd256, 16'd256, 16'd255, 16'h5A5A));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            release_in();
            wait_drained();
            program_grid(p);
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 46;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 46;
                end
                default:
                begin
                    idle_pct = 24;
                    stall_pct = 24;
                end
            endcase
            for (int i = 0; i < SEGS_PER_PHASE; i++)
            begin
                send_segment(make_segment());
                if (p == 1 && i == 19)
                begin
                    // hold off until the walker has emptied out
                    release_in();
                    wait_drained();
                    repeat (40)
                        @(posedge clk);
                end
            end
        end

        release_in();
        wait_drained();
        repeat (100)
            @(posedge clk);
        if (board.cells_due.size() != 0)
            board.report("cells still outstanding at end of run");
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
